// File: hw/rtl/crcfix_pkg.sv
// crc-16 constants, nibble table and reserved-byte helpers
`timescale 1ns / 1ps
package crcfix_pkg;

   localparam int unsigned CrcWidth  = 16;
   localparam int unsigned ByteWidth = 8;

   typedef logic [CrcWidth-1:0]  crc_type;
   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [3:0]           nibble_type;

   localparam byte_type RSV_PAREN = 8'h28;
   localparam byte_type RSV_CR    = 8'h0D;
   localparam byte_type RSV_LF    = 8'h0A;

   // remainder of each nibble placed in the top nibble, polynomial 0x1021
   localparam crc_type NIBBLE_TABLE [16] = '{
      16'h0000, 16'h1021, 16'h2042, 16'h3063,
      16'h4084, 16'h50A5, 16'h60C6, 16'h70E7,
      16'h8108, 16'h9129, 16'hA14A, 16'hB16B,
      16'hC18C, 16'hD1AD, 16'hE1CE, 16'hF1EF
   };

   function automatic crc_type feed_nibble(input crc_type crc, input nibble_type nib);
      nibble_type idx;
      idx = crc[15:12] ^ nib;
      return NIBBLE_TABLE[idx] ^ {crc[11:0], 4'h0};
   endfunction

   function automatic logic is_reserved(input byte_type b);
      return (b == RSV_PAREN) || (b == RSV_CR) || (b == RSV_LF);
   endfunction

   function automatic byte_type fix_byte(input byte_type b);
      return is_reserved(b) ? byte_type'(b + byte_type'(1)) : b;
   endfunction

endpackage

// File: hw/rtl/crc16_reserved_byte_fixup_top.sv
// top level: byte-serial crc-16 with reserved-byte adjustment of the result
`timescale 1ns / 1ps
// the crc of an accepted last byte is registered before it shows on rsp_crc_value
// throughput: one byte per cycle while req_stall is low; the combinational byte update sets this
// a held result stalls only a last byte; other bytes keep flowing
// reset clears the running crc to zero and drops rsp_valid
module crc16_reserved_byte_fixup_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  crcfix_pkg::byte_type req_data_byte,
   input  logic                 req_last_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output crcfix_pkg::crc_type  rsp_crc_value
);
   import crcfix_pkg::*;

   crc_type running_crc_ff, running_crc_in;
   crc_type rsp_crc_ff, rsp_crc_in;
   logic    rsp_valid_ff, rsp_valid_in;
   crc_type crc_next, crc_fixed;
   logic    req_take, rsp_take;

   crcfix_step u_step (
      .crc_in    (running_crc_ff),
      .data_byte (req_data_byte),
      .crc_next  (crc_next),
      .crc_fixed (crc_fixed)
   );

   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = rsp_valid_ff && rsp_stall && req_last_byte;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      running_crc_in = running_crc_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_take;
      rsp_crc_in     = rsp_crc_ff;
      if (req_take) begin
         if (req_last_byte) begin
            running_crc_in = '0;
            rsp_valid_in   = 1'b1;
            rsp_crc_in     = crc_fixed;
         end else begin
            running_crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         running_crc_ff <= running_crc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

   // a last byte always leaves a result and a cleared crc behind
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_take && req_last_byte |=> rsp_valid_ff && running_crc_ff == '0)
      else $error("last byte did not produce a result or clear the crc");

   // other bytes fold into the running crc
   a_mid_update: assert property (@(posedge clock) disable iff (reset)
      req_take && !req_last_byte |=> running_crc_ff == $past(crc_next))
      else $error("running crc not updated by a middle byte");

   // no reserved value ever leaves in either byte
   a_no_reserved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !is_reserved(rsp_crc_ff[7:0]) && !is_reserved(rsp_crc_ff[15:8]))
      else $error("reserved byte in result");

   // a waiting result is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !(req_take && req_last_byte))
      else $error("last byte taken while result held");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && running_crc_ff == '0)
      else $error("state not cleared by reset");

endmodule

// File: hw/rtl/crcfix_step.sv
// byte-wide crc update and reserved-byte adjustment of the result
`timescale 1ns / 1ps
module crcfix_step (
   input  crcfix_pkg::crc_type  crc_in,
   input  crcfix_pkg::byte_type data_byte,
   output crcfix_pkg::crc_type  crc_next,
   output crcfix_pkg::crc_type  crc_fixed
);
   import crcfix_pkg::*;

   crc_type crc_mid;

   always_comb begin
      crc_mid   = feed_nibble(crc_in, data_byte[7:4]);
      crc_next  = feed_nibble(crc_mid, data_byte[3:0]);
      // no carry between bytes, so each byte is adjusted on its own
      crc_fixed = {fix_byte(crc_next[15:8]), fix_byte(crc_next[7:0])};
   end

endmodule
